[sv/csvc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvc_pkg
// types and constants shared by the csv character classifier files
// ----------------------------------------------------------------------------
package csvc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CLASS_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'd0;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0] FIELD_SEP_RST  = 8'd44;
    localparam logic [BYTE_W-1:0] QUOTE_CHAR_RST = 8'd34;
    localparam logic [BYTE_W-1:0] RECORD_SEP_RST = 8'd10;
    localparam logic              AUTO_EOL_RST   = 1'b1;

    typedef enum logic [CLASS_W-1:0] {
        CLS_TEXT      = 3'd0,
        CLS_FIELD_SEP = 3'd1,
        CLS_REC_SEP   = 3'd2,
        CLS_OPEN_Q    = 3'd3,
        CLS_CLOSE_Q   = 3'd4,
        CLS_END       = 3'd5
    } char_class_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIELD_SEP  = 3'd0,
        REG_QUOTE_CHAR = 3'd1,
        REG_RECORD_SEP = 3'd2,
        REG_AUTO_EOL   = 3'd3
    } cfg_reg_e;

    typedef struct packed {
        logic [BYTE_W-1:0] field_sep;
        logic [BYTE_W-1:0] quote_char;
        logic [BYTE_W-1:0] record_sep;
        logic              auto_eol;
    } csvc_cfg_t;

    // stream context that the classification of one byte depends on
    typedef struct packed {
        logic [BYTE_W-1:0] prev_byte;
        logic              inside_quotes;
        logic              at_start;
    } csvc_ctx_t;

    typedef struct packed {
        char_class_e cls;
        logic        pair;
        logic        inside_quotes;
    } csvc_verdict_t;

endpackage

[sv/csvc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvc_in_if / csvc_out_if
// valid/ready channels for raw bytes in and classified characters out
// ----------------------------------------------------------------------------
interface csvc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface csvc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] char_class;
    logic [7:0] char_byte;
    logic       out_last;

    modport source (output valid, output char_class, output char_byte, output out_last,
                    input ready);
    modport sink   (input valid, input char_class, input char_byte, input out_last,
                    output ready);
endinterface

[sv/csvc_classify.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvc_classify
// classifies one byte from its context and the byte after it
// ----------------------------------------------------------------------------
module csvc_classify
(
    input  csvc_pkg::csvc_cfg_t       cfg,
    input  csvc_pkg::csvc_ctx_t       ctx,
    input  logic [7:0]                cur_byte,
    input  logic                      has_next,
    input  logic [7:0]                next_byte,
    output csvc_pkg::csvc_verdict_t   verdict
);

    logic prev_ends;
    logic cur_ends;
    logic next_ends;
    logic is_quote;
    logic q_open;
    logic q_esc;
    logic q_close;

    always_comb
    begin
        if (cfg.auto_eol)
        begin
            prev_ends = (ctx.prev_byte == csvc_pkg::CH_CR) || (ctx.prev_byte == csvc_pkg::CH_LF);
            cur_ends  = (cur_byte == csvc_pkg::CH_CR) || (cur_byte == csvc_pkg::CH_LF);
            next_ends = (next_byte == csvc_pkg::CH_CR) || (next_byte == csvc_pkg::CH_LF);
        end
        else
        begin
            prev_ends = (ctx.prev_byte == cfg.record_sep);
            cur_ends  = (cur_byte == cfg.record_sep);
            next_ends = (next_byte == cfg.record_sep);
        end
    end

    assign is_quote = (cur_byte == cfg.quote_char);
    assign q_open   = is_quote && (ctx.at_start ||
                      (!ctx.inside_quotes && ((ctx.prev_byte == cfg.field_sep) || prev_ends)));
    assign q_esc    = is_quote && !q_open && has_next && (next_byte == cfg.quote_char);
    assign q_close  = is_quote && !q_open && !q_esc && ctx.inside_quotes &&
                      (!has_next || (next_byte == cfg.field_sep) || next_ends);

    always_comb
    begin
        // separator test first, even when it equals the quote
        priority if (!ctx.inside_quotes && (cur_byte == cfg.field_sep))
            verdict.cls = csvc_pkg::CLS_FIELD_SEP;
        else if (q_open)
            verdict.cls = csvc_pkg::CLS_OPEN_Q;
        else if (q_close)
            verdict.cls = csvc_pkg::CLS_CLOSE_Q;
        else if (q_esc || ctx.inside_quotes)
            verdict.cls = csvc_pkg::CLS_TEXT;
        else if (cur_ends)
            verdict.cls = csvc_pkg::CLS_REC_SEP;
        else
            verdict.cls = csvc_pkg::CLS_TEXT;

        // doubled quote or cr lf swallows the following byte
        verdict.pair = q_esc ||
                       ((cur_byte == csvc_pkg::CH_CR) && has_next &&
                        (next_byte == csvc_pkg::CH_LF));

        if (verdict.cls == csvc_pkg::CLS_OPEN_Q)
            verdict.inside_quotes = 1'b1;
        else if (verdict.cls == csvc_pkg::CLS_CLOSE_Q)
            verdict.inside_quotes = 1'b0;
        else
            verdict.inside_quotes = ctx.inside_quotes;
    end

endmodule

[sv/csv_char_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_char_classifier
// splits a csv byte stream into classified characters with a lookahead window
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                           notes
//  in_ch     in    in_byte[7:0], in_last             one raw byte per item
//  out_ch    out   char_class[2:0], char_byte[7:0],  one character per item
//                  out_last
//  cfg       in    cfg_we, cfg_index[2:0],           write only, no wait
//                  cfg_wdata[7:0]
//
//  a byte that is not the last is taken every cycle while the output register
//  is empty or being drained; the result of each step (if any) is registered.
//  results trail the input by two bytes, held in a three-byte window.
//  the last byte starts a flush of the window: one byte leaves per cycle while
//  the output register is free, and no new byte is taken during the flush.
//  rst_n clears the stream state and loads the register defaults at once.
//  a stall on out_ch holds the result register and stops input taking.
//
module csv_char_classifier
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    csvc_in_if.sink                               in_ch,
    csvc_out_if.source                            out_ch,
    input  logic                                  cfg_we,
    input  logic [csvc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [csvc_pkg::BYTE_W-1:0]           cfg_wdata
);

    // configuration
    csvc_pkg::csvc_cfg_t cfg_reg;

    // stream state
    logic [7:0]          win_reg   [3];
    logic [7:0]          win_next  [3];
    logic [1:0]          cnt_reg,  cnt_next;    // bytes held in the window
    logic                flush_reg, flush_next; // draining after the last byte
    logic                skip_reg,  skip_next;  // next byte already consumed
    csvc_pkg::csvc_ctx_t ctx_reg,   ctx_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    csvc_pkg::char_class_e out_class_reg, out_class_next;
    logic [7:0]            out_byte_reg,  out_byte_next;
    logic                  out_last_reg,  out_last_next;

    // classifier hookup
    logic                    has_next;
    logic [7:0]              next_byte;
    csvc_pkg::csvc_verdict_t verdict;

    logic out_free;
    logic in_take;
    logic step_byte;
    logic end_plain;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = !flush_reg && out_free;
    assign in_take   = in_ch.valid && in_ch.ready;

    // a full window plus a new byte, or a flush step, classifies the oldest byte
    assign step_byte = (in_take && !in_ch.in_last && (cnt_reg == 2'd2)) ||
                       (flush_reg && out_free && (cnt_reg != 2'd0));
    // window drained without a trailing line break: plain end item
    assign end_plain = flush_reg && out_free && (cnt_reg == 2'd0);

    assign has_next  = flush_reg ? (cnt_reg >= 2'd2) : 1'b1;
    assign next_byte = has_next ? win_reg[1] : csvc_pkg::CH_NUL;

    csvc_classify u_classify
    (
        .cfg       (cfg_reg),
        .ctx       (ctx_reg),
        .cur_byte  (win_reg[0]),
        .has_next  (has_next),
        .next_byte (next_byte),
        .verdict   (verdict)
    );

    always_comb
    begin
        win_next       = win_reg;
        cnt_next       = cnt_reg;
        flush_next     = flush_reg;
        skip_next      = skip_reg;
        ctx_next       = ctx_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_class_next = out_class_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        // loading the window
        if (in_take)
        begin
            if (!in_ch.in_last && (cnt_reg == 2'd2))
            begin
                win_next[0] = win_reg[1];
                win_next[1] = in_ch.in_byte;
            end
            else
            begin
                unique case (cnt_reg)
                    2'd0:    win_next[0] = in_ch.in_byte;
                    2'd1:    win_next[1] = in_ch.in_byte;
                    2'd2:    win_next[2] = in_ch.in_byte;
                    default: win_next[2] = in_ch.in_byte;
                endcase
                cnt_next   = cnt_reg + 2'd1;
                flush_next = in_ch.in_last;
            end
        end

        // draining: oldest byte leaves, window shifts down
        if (flush_reg && step_byte)
        begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end

        if (step_byte)
        begin
            ctx_next.prev_byte = win_reg[0];
            if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else
            begin
                ctx_next.at_start      = 1'b0;
                ctx_next.inside_quotes = verdict.inside_quotes;
                out_valid_next         = 1'b1;
                out_byte_next          = win_reg[0];
                // line break with nothing (or a lone cr) after it ends the data
                if (flush_reg && (verdict.cls == csvc_pkg::CLS_REC_SEP) &&
                    (!has_next || ((win_reg[1] == csvc_pkg::CH_CR) && (cnt_reg == 2'd2))))
                begin
                    out_class_next = csvc_pkg::CLS_END;
                    out_last_next  = 1'b1;
                    cnt_next       = 2'd0;
                    flush_next     = 1'b0;
                    skip_next      = 1'b0;
                    ctx_next       = '{prev_byte: csvc_pkg::CH_NUL, inside_quotes: 1'b0,
                                       at_start: 1'b1};
                end
                else
                begin
                    out_class_next = verdict.cls;
                    out_last_next  = 1'b0;
                    skip_next      = verdict.pair;
                end
            end
        end

        if (end_plain)
        begin
            out_valid_next = 1'b1;
            out_class_next = csvc_pkg::CLS_END;
            out_byte_next  = csvc_pkg::CH_NUL;
            out_last_next  = 1'b1;
            cnt_next       = 2'd0;
            flush_next     = 1'b0;
            skip_next      = 1'b0;
            ctx_next       = '{prev_byte: csvc_pkg::CH_NUL, inside_quotes: 1'b0,
                               at_start: 1'b1};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 2'd0;
            flush_reg     <= 1'b0;
            skip_reg      <= 1'b0;
            ctx_reg       <= '{prev_byte: csvc_pkg::CH_NUL, inside_quotes: 1'b0,
                               at_start: 1'b1};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            flush_reg     <= flush_next;
            skip_reg      <= skip_next;
            ctx_reg       <= ctx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        out_class_reg <= out_class_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{field_sep:  csvc_pkg::FIELD_SEP_RST,
                         quote_char: csvc_pkg::QUOTE_CHAR_RST,
                         record_sep: csvc_pkg::RECORD_SEP_RST,
                         auto_eol:   csvc_pkg::AUTO_EOL_RST};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csvc_pkg::REG_FIELD_SEP:  cfg_reg.field_sep  <= cfg_wdata;
                csvc_pkg::REG_QUOTE_CHAR: cfg_reg.quote_char <= cfg_wdata;
                csvc_pkg::REG_RECORD_SEP: cfg_reg.record_sep <= cfg_wdata;
                csvc_pkg::REG_AUTO_EOL:   cfg_reg.auto_eol   <= cfg_wdata[0];
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.char_class = out_class_reg;
    assign out_ch.char_byte  = out_byte_reg;
    assign out_ch.out_last   = out_last_reg;

    // outside a flush the window never holds more than two bytes
    a_window_depth: assert property (@(posedge clk) disable iff (!rst_n)
        !flush_reg |-> (cnt_reg != 2'd3))
        else $error("window holds three bytes outside a flush");

    // every flush closes with an end item in the result register
    a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(flush_reg) |-> (out_valid_reg && out_last_reg &&
                              (out_class_reg == csvc_pkg::CLS_END)))
        else $error("flush finished without an end item");

    // the end marker and the end class always travel together
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_class_reg == csvc_pkg::CLS_END)))
        else $error("out_last and end class disagree");

endmodule
